/* hdl/lbc_pkg.sv */
// Shared codes and types for the LRU block cache with pins.
package lbc_pkg;

  // Request modes.
  localparam logic [2:0] MODE_ACCESS = 3'd0;
  localparam logic [2:0] MODE_EVICT  = 3'd1;
  localparam logic [2:0] MODE_FLUSH  = 3'd2;
  localparam logic [2:0] MODE_DROP   = 3'd3;
  localparam logic [2:0] MODE_PIN    = 3'd4;
  localparam logic [2:0] MODE_DIRTY  = 3'd5;

  // Result kinds.
  localparam logic [2:0] KIND_HIT   = 3'd0;
  localparam logic [2:0] KIND_MISS  = 3'd1;
  localparam logic [2:0] KIND_WB    = 3'd2;
  localparam logic [2:0] KIND_CLEAN = 3'd3;
  localparam logic [2:0] KIND_FULL  = 3'd4;
  localparam logic [2:0] KIND_NONE  = 3'd5;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOC_RD,
    ST_LOC_CMP,
    ST_VIC_SCAN,
    ST_VIC_RD,
    ST_VIC_REL,
    ST_FILL,
    ST_FL_RD,
    ST_FL_REL,
    ST_DR_RD,
    ST_DR_CMP,
    ST_DR_REL,
    ST_FINISH
  } state_t;

  // One result word before the slot index is narrowed to the port.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  file_id;
    logic [31:0] offset;
  } res_t;

endpackage

/* hdl/lru_block_cache_with_pins_unit.sv */
// Top level of the fully associative LRU block cache with pinning.
//
// Usage: a request word (mode, file_id, block_offset, pin_value) is taken at a
// rising edge where start is high and busy is low. The block then walks its
// recency list and answers with one or more result words, each shown for one
// cycle with done high; the last word of a request has last set. A request
// always gives at least one word (kind none when there is nothing to do).
// Flow: block tags sit in one RAM with a registered read, so each list
// position visited takes a read state and then a compare state. An access hit
// walks the list up to the hit. A miss walks the whole list and then fills; on
// a full cache the victim scan first steps over the pinned slots ahead of the
// victim, then reads and releases it. A flush reads and releases each block in
// turn, and a drop scans the whole list, releases the lowest-offset block of
// the file and scans again until none is left.
// One request is worked on at a time; busy stays high until its last word has
// been issued. The receiver cannot stall: every word is final when shown.
// Reset (synchronous, active high) empties the list, refills the free stack
// with slot 0 on top and clears all dirty marks and pin counts at once; tag
// RAM contents are left as they are.
module lru_block_cache_with_pins_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [7:0]  file_id,
  input  logic [31:0] block_offset,
  input  logic [7:0]  pin_value,
  output logic        done,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic [7:0]  out_file_id,
  output logic [31:0] out_offset,
  output logic        last
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  lbc_pkg::state_t state, state_next;

  // Request registers.
  logic [2:0]  req_mode;
  logic [7:0]  req_file;
  logic [31:0] req_off;
  logic [7:0]  req_pin;

  // Cache state kept in flip-flops.
  logic [SW-1:0] order [CAPACITY];
  logic [CW-1:0] cnt;
  logic [SW-1:0] free_stk [CAPACITY];
  logic [CW-1:0] free_cnt;
  logic          dirty [CAPACITY];
  logic [7:0]    pins [CAPACITY];

  // Scan state.
  logic [CW-1:0] p;
  logic          best_v;
  logic [CW-1:0] best_p;
  logic [31:0]   best_off;
  logic [SW-1:0] best_slot;

  // Pending result word, held until the next one shows whether it is last.
  logic             pend_v;
  lbc_pkg::res_t    pend;
  logic [SW-1:0]    pend_slot;

  // Tag RAM.
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [39:0]   ram_rdata;
  logic [SW-1:0] ram_raddr;

  // Combinational controls.
  logic          emit_en;
  lbc_pkg::res_t emit_res;
  logic [SW-1:0] emit_slot;
  logic          rm_en;
  logic [CW-1:0] rm_pos;
  logic          app_en;
  logic [SW-1:0] app_slot;
  logic          clr_list;
  logic          push_en;
  logic [SW-1:0] push_slot;
  logic          pop_en;
  logic          slot_clr_en;
  logic [SW-1:0] slot_clr;
  logic          pin_set_en;
  logic          dirty_set_en;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] free_top;
  logic [CW-1:0] last_p;
  logic          last_pos;
  logic          match;
  logic          dr_cand;
  logic [CW-1:0] cnt_rm;

  assign cur_slot = order[p[SW-1:0]];
  assign free_top = free_stk[SW'(free_cnt - CW'(1))];
  assign last_p   = CW'(cnt - CW'(1));
  assign last_pos = (p == last_p);
  assign match    = (ram_rdata == {req_file, req_off});
  assign dr_cand  = (ram_rdata[39:32] == req_file) &&
                    (!best_v || (ram_rdata[31:0] < best_off));
  assign busy     = (state != lbc_pkg::ST_IDLE);

  lbc_ram #(
    .WIDTH(40),
    .DEPTH(CAPACITY)
  ) u_tags (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({req_file, req_off}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      lbc_pkg::ST_IDLE: begin
        if (start) begin
          if (mode == lbc_pkg::MODE_FLUSH) begin
            state_next = (cnt != '0) ? lbc_pkg::ST_FL_RD : lbc_pkg::ST_FINISH;
          end else if (mode == lbc_pkg::MODE_DROP) begin
            state_next = (cnt != '0) ? lbc_pkg::ST_DR_RD : lbc_pkg::ST_FINISH;
          end else if (mode == lbc_pkg::MODE_ACCESS || mode == lbc_pkg::MODE_EVICT ||
                       mode == lbc_pkg::MODE_PIN || mode == lbc_pkg::MODE_DIRTY) begin
            if (cnt != '0) begin
              state_next = lbc_pkg::ST_LOC_RD;
            end else if (mode == lbc_pkg::MODE_ACCESS) begin
              state_next = (free_cnt == '0) ? lbc_pkg::ST_VIC_SCAN : lbc_pkg::ST_FILL;
            end else begin
              state_next = lbc_pkg::ST_FINISH;
            end
          end else begin
            state_next = lbc_pkg::ST_FINISH;
          end
        end
      end
      lbc_pkg::ST_LOC_RD: state_next = lbc_pkg::ST_LOC_CMP;
      lbc_pkg::ST_LOC_CMP: begin
        if (match) begin
          state_next = lbc_pkg::ST_FINISH;
        end else if (!last_pos) begin
          state_next = lbc_pkg::ST_LOC_RD;
        end else if (req_mode == lbc_pkg::MODE_ACCESS) begin
          state_next = (free_cnt == '0) ? lbc_pkg::ST_VIC_SCAN : lbc_pkg::ST_FILL;
        end else begin
          state_next = lbc_pkg::ST_FINISH;
        end
      end
      lbc_pkg::ST_VIC_SCAN: begin
        if (p == cnt) begin
          state_next = lbc_pkg::ST_FINISH;
        end else if (pins[cur_slot] == 8'd0) begin
          state_next = lbc_pkg::ST_VIC_RD;
        end
      end
      lbc_pkg::ST_VIC_RD:  state_next = lbc_pkg::ST_VIC_REL;
      lbc_pkg::ST_VIC_REL: state_next = lbc_pkg::ST_FILL;
      lbc_pkg::ST_FILL:    state_next = lbc_pkg::ST_FINISH;
      lbc_pkg::ST_FL_RD:   state_next = lbc_pkg::ST_FL_REL;
      lbc_pkg::ST_FL_REL:
        state_next = last_pos ? lbc_pkg::ST_FINISH : lbc_pkg::ST_FL_RD;
      lbc_pkg::ST_DR_RD:   state_next = lbc_pkg::ST_DR_CMP;
      lbc_pkg::ST_DR_CMP: begin
        if (!last_pos) begin
          state_next = lbc_pkg::ST_DR_RD;
        end else begin
          state_next = (best_v || dr_cand) ? lbc_pkg::ST_DR_REL : lbc_pkg::ST_FINISH;
        end
      end
      lbc_pkg::ST_DR_REL:
        state_next = (cnt == CW'(1)) ? lbc_pkg::ST_FINISH : lbc_pkg::ST_DR_RD;
      lbc_pkg::ST_FINISH:  state_next = lbc_pkg::ST_IDLE;
      default:             state_next = lbc_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath controls for each state.
  always_comb begin
    emit_en      = 1'b0;
    emit_res     = '0;
    emit_slot    = '0;
    rm_en        = 1'b0;
    rm_pos       = p;
    app_en       = 1'b0;
    app_slot     = cur_slot;
    clr_list     = 1'b0;
    push_en      = 1'b0;
    push_slot    = cur_slot;
    pop_en       = 1'b0;
    slot_clr_en  = 1'b0;
    slot_clr     = cur_slot;
    pin_set_en   = 1'b0;
    dirty_set_en = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = free_top;
    ram_raddr    = cur_slot;
    unique case (state)
      lbc_pkg::ST_LOC_CMP: begin
        if (match) begin
          emit_en   = 1'b1;
          emit_slot = cur_slot;
          emit_res  = '{kind: lbc_pkg::KIND_HIT, file_id: req_file, offset: req_off};
          if (req_mode == lbc_pkg::MODE_ACCESS) begin
            rm_en  = 1'b1;
            app_en = 1'b1;
          end else if (req_mode == lbc_pkg::MODE_EVICT) begin
            emit_res.kind = dirty[cur_slot] ? lbc_pkg::KIND_WB : lbc_pkg::KIND_CLEAN;
            rm_en       = 1'b1;
            push_en     = 1'b1;
            slot_clr_en = 1'b1;
          end else if (req_mode == lbc_pkg::MODE_PIN) begin
            pin_set_en = 1'b1;
          end else begin
            dirty_set_en = 1'b1;
          end
        end
      end
      lbc_pkg::ST_VIC_SCAN: begin
        if (p == cnt) begin
          emit_en  = 1'b1;
          emit_res = '{kind: lbc_pkg::KIND_FULL, file_id: req_file, offset: req_off};
        end
      end
      lbc_pkg::ST_VIC_REL, lbc_pkg::ST_FL_REL: begin
        emit_en   = 1'b1;
        emit_slot = cur_slot;
        emit_res  = '{kind: dirty[cur_slot] ? lbc_pkg::KIND_WB : lbc_pkg::KIND_CLEAN,
                      file_id: ram_rdata[39:32], offset: ram_rdata[31:0]};
        push_en     = 1'b1;
        slot_clr_en = 1'b1;
        if (state == lbc_pkg::ST_VIC_REL) begin
          rm_en = 1'b1;
        end else if (last_pos) begin
          clr_list = 1'b1;
        end
      end
      lbc_pkg::ST_FILL: begin
        ram_we      = 1'b1;
        pop_en      = 1'b1;
        app_en      = 1'b1;
        app_slot    = free_top;
        slot_clr_en = 1'b1;
        slot_clr    = free_top;
        emit_en     = 1'b1;
        emit_slot   = free_top;
        emit_res    = '{kind: lbc_pkg::KIND_MISS, file_id: req_file, offset: req_off};
      end
      lbc_pkg::ST_DR_REL: begin
        emit_en     = 1'b1;
        emit_slot   = best_slot;
        emit_res    = '{kind: dirty[best_slot] ? lbc_pkg::KIND_WB : lbc_pkg::KIND_CLEAN,
                        file_id: req_file, offset: best_off};
        rm_en       = 1'b1;
        rm_pos      = best_p;
        push_en     = 1'b1;
        push_slot   = best_slot;
        slot_clr_en = 1'b1;
        slot_clr    = best_slot;
      end
      default: begin
      end
    endcase
  end

  assign cnt_rm = rm_en ? CW'(cnt - CW'(1)) : cnt;

  // Sequencer, scan and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lbc_pkg::ST_IDLE;
      pend_v <= 1'b0;
      done   <= 1'b0;
      best_v <= 1'b0;
      p      <= '0;
    end else begin
      state <= state_next;
      // A word is shown when a new one pushes the pending one out, and at the end.
      done  <= (emit_en && pend_v) || (state == lbc_pkg::ST_FINISH);

      // Scan position and best candidate.
      case (state)
        lbc_pkg::ST_IDLE: begin
          p      <= '0;
          best_v <= 1'b0;
          if (start) begin
            req_mode <= mode;
            req_file <= file_id;
            req_off  <= block_offset;
            req_pin  <= pin_value;
          end
        end
        lbc_pkg::ST_LOC_CMP: begin
          p <= (match || last_pos) ? '0 : CW'(p + CW'(1));
        end
        lbc_pkg::ST_VIC_SCAN: begin
          if (p != cnt && pins[cur_slot] != 8'd0) begin
            p <= CW'(p + CW'(1));
          end
        end
        lbc_pkg::ST_FL_REL: p <= CW'(p + CW'(1));
        lbc_pkg::ST_DR_CMP: begin
          if (dr_cand) begin
            best_v    <= 1'b1;
            best_p    <= p;
            best_off  <= ram_rdata[31:0];
            best_slot <= cur_slot;
          end
          p <= last_pos ? '0 : CW'(p + CW'(1));
        end
        lbc_pkg::ST_DR_REL: best_v <= 1'b0;
        default: begin
        end
      endcase

      // A new word pushes the pending one out, not last.
      if (emit_en) begin
        if (pend_v) begin
          last        <= 1'b0;
          kind        <= pend.kind;
          slot        <= 4'(pend_slot);
          out_file_id <= pend.file_id;
          out_offset  <= pend.offset;
        end
        pend_v    <= 1'b1;
        pend      <= emit_res;
        pend_slot <= emit_slot;
      end

      // The request ends with the pending word, or a word of kind none.
      if (state == lbc_pkg::ST_FINISH) begin
        last   <= 1'b1;
        pend_v <= 1'b0;
        if (pend_v) begin
          kind        <= pend.kind;
          slot        <= 4'(pend_slot);
          out_file_id <= pend.file_id;
          out_offset  <= pend.offset;
        end else begin
          kind        <= lbc_pkg::KIND_NONE;
          slot        <= '0;
          out_file_id <= '0;
          out_offset  <= '0;
        end
      end
    end
  end

  // Recency list, free stack and per-slot marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      free_cnt <= CW'(CAPACITY);
      for (int i = 0; i < CAPACITY; i++) begin
        free_stk[i] <= SW'(CAPACITY - 1 - i);
        dirty[i]    <= 1'b0;
        pins[i]     <= 8'd0;
      end
    end else begin
      // Removal shifts the younger entries down; an append goes on the end.
      for (int i = 0; i < CAPACITY; i++) begin
        if (app_en && CW'(i) == cnt_rm) begin
          order[i] <= app_slot;
        end else if (rm_en && CW'(i) >= rm_pos && i < CAPACITY - 1) begin
          order[i] <= order[(i + 1) % CAPACITY];
        end
      end
      if (clr_list) begin
        cnt <= '0;
      end else begin
        cnt <= app_en ? CW'(cnt_rm + CW'(1)) : cnt_rm;
      end

      // Free stack.
      if (push_en) begin
        free_stk[SW'(free_cnt)] <= push_slot;
        free_cnt <= CW'(free_cnt + CW'(1));
      end else if (pop_en) begin
        free_cnt <= CW'(free_cnt - CW'(1));
      end

      // Dirty marks and pin counts.
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_clr_en && SW'(i) == slot_clr) begin
          dirty[i] <= 1'b0;
          pins[i]  <= 8'd0;
        end else if (SW'(i) == cur_slot) begin
          if (pin_set_en) begin
            pins[i] <= req_pin;
          end
          if (dirty_set_en) begin
            dirty[i] <= 1'b1;
          end
        end
      end
    end
  end

endmodule

/* hdl/lbc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module lbc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lbc_checker.sv */
// Port-level checks for the LRU block cache with pins, bound to the top level.
module lbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  kind,
  input logic [3:0]  slot,
  input logic [7:0]  out_file_id,
  input logic        last
);

  // An accepted request always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // The end of a request shows its last word.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done && last)
    else $error("request ended without a last word");

  // No word appears while idle except the closing one.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    done && !busy |-> last)
    else $error("stray word while idle");

  // A full error or a word of kind none closes its request.
  a_single_kinds: assert property (@(posedge clk) disable iff (rst)
    done && (kind == lbc_pkg::KIND_FULL || kind == lbc_pkg::KIND_NONE) |-> last)
    else $error("full or none word not last");

  // A word of kind none carries no slot or file.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && kind == lbc_pkg::KIND_NONE |-> slot == 4'd0 && out_file_id == 8'd0)
    else $error("none word carries data");

endmodule

bind lru_block_cache_with_pins_unit lbc_checker u_lbc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .kind       (kind),
  .slot       (slot),
  .out_file_id(out_file_id),
  .last       (last)
);

/* bench/lru_block_cache_with_pins_unit_checker.sv */
// Checker for the LRU block cache: predicts result words and compares them.
module lru_block_cache_with_pins_unit_checker #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  mode,
  input  logic [7:0]  file_id,
  input  logic [31:0] block_offset,
  input  logic [7:0]  pin_value,
  input  logic        done,
  input  logic [2:0]  kind,
  input  logic [3:0]  slot,
  input  logic [7:0]  out_file_id,
  input  logic [31:0] out_offset,
  input  logic        last,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  file_id;
    logic [31:0] offset;
    logic        last;
  } cache_word_t;

  cache_word_t expected_words[$];

  // Shadow copy of the cache state.
  logic        shadow_valid[CAPACITY];
  logic [7:0]  shadow_file[CAPACITY];
  logic [31:0] shadow_offset[CAPACITY];
  logic        shadow_dirty[CAPACITY];
  logic [7:0]  shadow_pins[CAPACITY];
  int          lru_list[$];
  int          free_slots[$];

  assign pending_words = expected_words.size();

  function automatic void push_word(logic [2:0] k, int s, logic [7:0] f, logic [31:0] o);
    cache_word_t w;
    w.kind = k;
    w.slot = s[3:0];
    w.file_id = f;
    w.offset = o;
    w.last = 1'b0;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_pins[i] = '0;
    end
    lru_list.delete();
    free_slots.delete();
    // The back of the queue is the top of the free stack.
    for (int i = CAPACITY - 1; i >= 0; i--) free_slots.insert(free_slots.size(), i);
  endfunction

  function automatic int find_block(logic [7:0] f, logic [31:0] o);
    for (int p = 0; p < lru_list.size(); p++) begin
      if (shadow_file[lru_list[p]] == f && shadow_offset[lru_list[p]] == o) return p;
    end
    return -1;
  endfunction

  // Releases the block at a list position and frees its slot.
  function automatic void release_block(int pos);
    int s;
    s = lru_list[pos];
    push_word(shadow_dirty[s] ? lbc_pkg::KIND_WB : lbc_pkg::KIND_CLEAN, s,
              shadow_file[s], shadow_offset[s]);
    shadow_valid[s] = 1'b0;
    shadow_dirty[s] = 1'b0;
    shadow_pins[s] = '0;
    lru_list.delete(pos);
    free_slots.insert(free_slots.size(), s);
  endfunction

  // Works out the words one request gives and updates the shadow state.
  function automatic void predict_request(logic [2:0] m, logic [7:0] f, logic [31:0] o,
                                          logic [7:0] pv);
    int before_count;
    int pos;
    int s;
    int victim;
    int best;
    before_count = expected_words.size();
    case (m)
      lbc_pkg::MODE_ACCESS: begin
        pos = find_block(f, o);
        if (pos >= 0) begin
          s = lru_list[pos];
          lru_list.delete(pos);
          lru_list.insert(lru_list.size(), s);
          push_word(lbc_pkg::KIND_HIT, s, f, o);
        end else begin
          victim = -2;
          if (free_slots.size() == 0) begin
            victim = -1;
            for (int v = 0; v < lru_list.size(); v++) begin
              if (shadow_pins[lru_list[v]] == 0) begin
                victim = v;
                break;
              end
            end
          end
          if (victim == -1) begin
            push_word(lbc_pkg::KIND_FULL, 0, f, o);
          end else begin
            if (victim >= 0) release_block(victim);
            s = free_slots[free_slots.size() - 1];
            free_slots.delete(free_slots.size() - 1);
            shadow_valid[s] = 1'b1;
            shadow_file[s] = f;
            shadow_offset[s] = o;
            shadow_dirty[s] = 1'b0;
            shadow_pins[s] = '0;
            lru_list.insert(lru_list.size(), s);
            push_word(lbc_pkg::KIND_MISS, s, f, o);
          end
        end
      end
      lbc_pkg::MODE_EVICT: begin
        pos = find_block(f, o);
        if (pos >= 0) release_block(pos);
      end
      lbc_pkg::MODE_FLUSH: begin
        while (lru_list.size() > 0) release_block(0);
      end
      lbc_pkg::MODE_DROP: begin
        // Blocks of the file go out in ascending offset order.
        forever begin
          best = -1;
          for (int p = 0; p < lru_list.size(); p++) begin
            if (shadow_file[lru_list[p]] == f &&
                (best < 0 || shadow_offset[lru_list[p]] < shadow_offset[lru_list[best]]))
              best = p;
          end
          if (best < 0) break;
          release_block(best);
        end
      end
      lbc_pkg::MODE_PIN, lbc_pkg::MODE_DIRTY: begin
        pos = find_block(f, o);
        if (pos >= 0) begin
          s = lru_list[pos];
          if (m == lbc_pkg::MODE_PIN) shadow_pins[s] = pv;
          else shadow_dirty[s] = 1'b1;
          push_word(lbc_pkg::KIND_HIT, s, f, o);
        end
      end
      default: ;
    endcase
    if (expected_words.size() == before_count) push_word(lbc_pkg::KIND_NONE, 0, '0, '0);
    expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  // Predict on each accepted request, compare each result word.
  always @(posedge clk) begin
    cache_word_t want;
    if (rst) begin
      reset_shadow();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: kind %0d slot %0d file %0d offset %h last %0d",
                     kind, slot, out_file_id, out_offset, last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (want.kind !== kind || want.slot !== slot || want.file_id !== out_file_id ||
              want.offset !== out_offset || want.last !== last) begin
            if (fail_count < 10)
              $display("mismatch: expected kind %0d slot %0d file %0d offset %h last %0d",
                       want.kind, want.slot, want.file_id, want.offset, want.last,
                       ", got kind %0d slot %0d file %0d offset %h last %0d",
                       kind, slot, out_file_id, out_offset, last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_request(mode, file_id, block_offset, pin_value);
    end
  end
endmodule

/* bench/lru_block_cache_with_pins_unit_test.sv */
// Stimulus and verdict for the LRU block cache with pins.
module lru_block_cache_with_pins_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [7:0]  file_id = '0;
  logic [31:0] block_offset = '0;
  logic [7:0]  pin_value = '0;
  logic        done;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [7:0]  out_file_id;
  logic [31:0] out_offset;
  logic        last;
  int          fail_count;
  int          pending_words;
  int          idle_cycles = 0;

  localparam int IDLE_LIMIT = 20000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_block_cache_with_pins_unit dut (.*);
  lru_block_cache_with_pins_unit_checker checker_i (.*);

  // Watchdog on cycles with no request or word accepted.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one request word and holds it until it is taken; start stays high.
  task automatic send_word(logic [2:0] m, logic [7:0] f, logic [31:0] o, logic [7:0] p);
    start <= 1'b1;
    mode <= m;
    file_id <= f;
    block_offset <= o;
    pin_value <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drops start and leaves the sender idle.
  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random request drawn mostly from a small set of blocks so hits are common.
  task automatic send_random();
    logic [2:0]  m;
    logic [7:0]  f;
    logic [31:0] o;
    int          r;
    r = $urandom_range(0, 99);
    m = r < 50 ? lbc_pkg::MODE_ACCESS : r < 62 ? lbc_pkg::MODE_EVICT :
        r < 65 ? lbc_pkg::MODE_FLUSH : r < 71 ? lbc_pkg::MODE_DROP :
        r < 84 ? lbc_pkg::MODE_PIN : r < 97 ? lbc_pkg::MODE_DIRTY :
        3'($urandom_range(6, 7));
    f = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    o = $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 7)) << 12;
    send_word(m, f, o, $urandom_range(0, 1) ? 8'd0 : 8'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, empty cases, fill to full, all pinned, bad modes.
    send_word(lbc_pkg::MODE_FLUSH, 8'd0, 32'd0, 8'd0);
    send_word(lbc_pkg::MODE_EVICT, 8'hFF, 32'hFFFF_FFFF, 8'd0);
    send_word(lbc_pkg::MODE_DROP, 8'd7, 32'd0, 8'd0);
    send_word(lbc_pkg::MODE_PIN, 8'd1, 32'd0, 8'hFF);
    send_word(lbc_pkg::MODE_DIRTY, 8'd1, 32'd0, 8'd0);
    send_word(3'd6, 8'hAA, 32'h5555_5555, 8'h55);
    send_word(3'd7, 8'h55, 32'hAAAA_AAAA, 8'hAA);
    for (int i = 0; i < 16; i++)
      send_word(lbc_pkg::MODE_ACCESS, i[0] ? 8'hFF : 8'h00,
                i[0] ? 32'hFFFF_FFF0 - i : 32'(i), 8'd0);
    for (int i = 0; i < 16; i++)
      send_word(lbc_pkg::MODE_PIN, i[0] ? 8'hFF : 8'h00,
                i[0] ? 32'hFFFF_FFF0 - i : 32'(i), 8'hFF);
    send_word(lbc_pkg::MODE_ACCESS, 8'h3C, 32'h1234_5678, 8'd0);
    send_word(lbc_pkg::MODE_DIRTY, 8'hFF, 32'hFFFF_FFEF, 8'd0);
    send_word(lbc_pkg::MODE_PIN, 8'h00, 32'd2, 8'd0);
    send_word(lbc_pkg::MODE_ACCESS, 8'h3C, 32'h1234_5678, 8'd0);
    send_word(lbc_pkg::MODE_ACCESS, 8'd0, 32'd4, 8'd0);
    send_word(lbc_pkg::MODE_EVICT, 8'hFF, 32'hFFFF_FFEF, 8'd0);
    send_word(lbc_pkg::MODE_DROP, 8'hFF, 32'd0, 8'd0);
    send_word(lbc_pkg::MODE_FLUSH, 8'd0, 32'd0, 8'd0);

    // Let every expected word arrive before the random part.
    pause_sender(1);
    while (pending_words != 0) @(posedge clk);

    // Random requests in bursts with gaps between them.
    for (int n = 0; n < 132; ) begin
      int burst;
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        send_random();
        n++;
      end
      pause_sender($urandom_range(1, 9));
      if ($urandom_range(0, 19) == 0) while (pending_words != 0) @(posedge clk);
    end

    while (pending_words != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/lbc_pkg.sv
hdl/lbc_ram.sv
hdl/lru_block_cache_with_pins_unit.sv
hdl/lbc_checker.sv
bench/lru_block_cache_with_pins_unit_checker.sv
bench/lru_block_cache_with_pins_unit_test.sv
